// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file lsm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== src/lsm_pkg.sv =====
package lsm_pkg;

  localparam int BYTE_W     = 8;
  localparam int PAT_BYTES  = 16;
  localparam int PAT_W      = PAT_BYTES * BYTE_W;
  localparam int LEN_W      = 5;
  localparam int PAT_IDX_W  = 4;
  localparam int INDEX_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_DATA_W = 40;
  localparam int MAX_PATTERN_DEFAULT = 16;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] pat_sel(input logic [PAT_W-1:0] pat,
                                                input logic [PAT_IDX_W-1:0] idx);
    return pat[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

// ===== src/lsm_cell.sv =====
module lsm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  lsm_pkg::cell_ctrl_t        ctrl,
  input  logic [lsm_pkg::BYTE_W-1:0] data_in,
  input  logic                       valid_in,
  input  logic [lsm_pkg::BYTE_W-1:0] pat_byte,
  input  logic                       active,
  output logic [lsm_pkg::BYTE_W-1:0] data_q,
  output logic                       valid_q,
  output logic                       ok
);
  import lsm_pkg::*;

  logic [BYTE_W-1:0] data;
  logic              valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= data_in;
    end
  end

  assign data_q  = data;
  assign valid_q = valid;
  assign ok      = !active || (valid && (data == pat_byte));

endmodule

// ===== src/line_substring_matcher_unit.sv =====
// Fixed-string line matcher: takes one text byte per cycle unless stalled and, for
// each line ended by a newline byte or by a byte with s_tlast set, returns one
// transaction with the line index, a matched flag and a final-line flag. The
// line result appears on the master side the cycle after its ending byte is
// taken. The recent bytes of the line sit in a row of MAX_PATTERN-1 cells that
// shift once per non-newline byte, each comparing its byte with its pattern
// byte, so the window compare finishes in the cycle of the byte. The input
// stalls only while a line result waits unaccepted on the output.
module line_substring_matcher_unit #(
  parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lsm_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // stream_end
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] line_index, [32] line_matched
  output logic                           m_tlast,   // final_line
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsm_pkg::*;

  localparam int HIST = MAX_PATTERN - 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [PAT_W-1:0]   pattern;
  logic [LEN_W-1:0]   pattern_length;
  logic [LEN_W-1:0]   len_eff;
  logic               line_hit;
  logic [INDEX_W-1:0] line_counter;
  logic [INDEX_W-1:0] out_index;
  logic               out_matched;
  logic               out_last;

  logic               accept;
  logic               is_nl;
  logic               emit;
  logic               hit_now;
  logic [BYTE_W-1:0]  last_pat;
  cell_ctrl_t         ctrl;

  logic [BYTE_W-1:0]  cell_data [HIST];
  logic [HIST-1:0]    cell_valid;
  logic [HIST-1:0]    cell_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern[CFG_DATA_W-1:0]     <= cfg_data;
        REG_PATTERN_HIGH:   pattern[PAT_W-1:CFG_DATA_W] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length              <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = pattern_length;
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_eff > MAX_LEN) begin
      len_eff = MAX_LEN;
    end
  end

  assign last_pat = pat_sel(pattern, PAT_IDX_W'(len_eff - LEN_W'(1)));

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign is_nl      = (s_tdata == NEWLINE);
  assign emit       = is_nl || s_tlast;
  assign ctrl.shift = accept && !is_nl;
  assign ctrl.clear = accept && emit;
  assign hit_now    = !is_nl && (&cell_ok) && (s_tdata == last_pat);

  for (genvar j = 0; j < HIST; j++) begin : g_cell
    logic [PAT_IDX_W-1:0] idx;
    logic                 active;
    logic [BYTE_W-1:0]    din;
    logic                 vin;

    assign idx    = PAT_IDX_W'(len_eff - LEN_W'(2) - LEN_W'(j));
    assign active = LEN_W'(j) < (len_eff - LEN_W'(1));

    if (j == 0) begin : g_head
      assign din = s_tdata;
      assign vin = 1'b1;
    end else begin : g_link
      assign din = cell_data[j-1];
      assign vin = cell_valid[j-1];
    end

    lsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .data_in  (din),
      .valid_in (vin),
      .pat_byte (pat_sel(pattern, idx)),
      .active   (active),
      .data_q   (cell_data[j]),
      .valid_q  (cell_valid[j]),
      .ok       (cell_ok[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      line_hit     <= 1'b0;
      line_counter <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        if (emit) begin
          m_tvalid     <= 1'b1;
          line_hit     <= 1'b0;
          line_counter <= s_tlast ? '0 : line_counter + INDEX_W'(1);
        end else begin
          line_hit <= line_hit || hit_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_index   <= line_counter;
      out_matched <= line_hit || hit_now;
      out_last    <= s_tlast;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - INDEX_W - 1){1'b0}}, out_matched, out_index};
  assign m_tlast = out_last;

endmodule

// ===== src/lsm_checker.sv =====
`include "assert_macros.svh"

module lsm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [lsm_pkg::BYTE_W-1:0]     s_tdata,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsm_pkg::*;

  logic in_acc;
  logic stalled;

  assign in_acc  = s_tvalid && s_tready;
  assign stalled = m_tvalid && !m_tready;

  `ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `ASSERT_SAME(a_in_blocked, clk, rst, stalled, !s_tready)
  `ASSERT_NEXT(a_last_result, clk, rst, in_acc && s_tlast, m_tvalid && m_tlast)
  `ASSERT_NEXT(a_nl_result, clk, rst, in_acc && (s_tdata == NEWLINE), m_tvalid)

endmodule

bind line_substring_matcher_unit lsm_checker u_lsm_checker (.*);

// ===== tb/tb_line_substring_matcher_unit.sv =====
`timescale 1ns / 1ps

module tb_line_substring_matcher_unit;
  import lsm_pkg::*;

  localparam int HIST           = PAT_BYTES - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 60;
  localparam int RANDOM_BYTES   = 450;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } text_byte_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic               matched;
    logic               final_line;
  } line_report_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  line_substring_matcher_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected line state, mirrors the block
  logic [PAT_W-1:0]   pattern     = '0;
  logic [LEN_W-1:0]   pattern_len = 5'd1;
  logic [BYTE_W-1:0]  window [HIST];
  int unsigned        line_fill;
  bit                 line_hit;
  logic [INDEX_W-1:0] line_count = '0;

  text_byte_t   text_q [$];
  line_report_t line_reports_due [$];
  int unsigned  bytes_queued = 0;
  int unsigned  mismatches   = 0;
  bit           idle_on      = 1'b1;
  bit           hold_req     = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int unsigned active_length();
    if (pattern_len == 0) return 1;
    if (pattern_len > PAT_BYTES) return PAT_BYTES;
    return 32'(pattern_len);
  endfunction

  function automatic void clear_line();
    for (int k = 0; k < HIST; k++) window[k] = '0;
    line_fill = 0;
    line_hit  = 1'b0;
  endfunction

  function automatic void scan_text_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned  len;
    bit           eq;
    line_report_t rep;
    len = active_length();
    if (b != NEWLINE) begin
      if (line_fill + 1 >= len && pattern[(len-1)*BYTE_W +: BYTE_W] == b) begin
        eq = 1'b1;
        for (int k = 1; k < len; k++)
          if (window[k-1] != pattern[(len-1-k)*BYTE_W +: BYTE_W]) eq = 1'b0;
        if (eq) line_hit = 1'b1;
      end
      for (int k = HIST - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (line_fill < PAT_BYTES) line_fill++;
    end
    if (b == NEWLINE || last) begin
      rep.index      = line_count;
      rep.matched    = line_hit;
      rep.final_line = last;
      line_reports_due.push_back(rep);
      clear_line();
      line_count = last ? '0 : line_count + 1'b1;
    end
  endfunction

  // byte driver
  int unsigned src_gap = 0;
  always @(posedge clk) begin : text_driver
    text_byte_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_line();
    end else begin
      if (s_tvalid && s_tready) scan_text_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (text_q.size() > 0) begin
          item = text_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.data;
          s_tlast  <= item.last;
          if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // report monitor and sink backpressure
  int unsigned sink_gap  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin : report_sink
    line_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (line_reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected report tdata=%h tlast=%b", m_tdata, m_tlast));
        end else begin
          want = line_reports_due.pop_front();
          if (m_tdata[INDEX_W-1:0] !== want.index)
            report_mismatch($sformatf("line_index %0d, want %0d",
                                      m_tdata[INDEX_W-1:0], want.index));
          if (m_tdata[INDEX_W] !== want.matched)
            report_mismatch($sformatf("line %0d: line_matched %b, want %b",
                                      want.index, m_tdata[INDEX_W], want.matched));
          if (m_tlast !== want.final_line)
            report_mismatch($sformatf("line %0d: final_line %b, want %b",
                                      want.index, m_tlast, want.final_line));
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] timeout, %0d reports outstanding", $time, line_reports_due.size());
      $display("tb_line_substring_matcher_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    pattern[CFG_DATA_W-1:0]          = value;
      REG_PATTERN_HIGH:   pattern[PAT_W-1:CFG_DATA_W]      = value;
      REG_PATTERN_LENGTH: pattern_len                      = value[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send(input logic [BYTE_W-1:0] b, input logic last);
    text_byte_t item;
    item.data = b;
    item.last = last;
    text_q.push_back(item);
    bytes_queued++;
  endtask

  // idle: nothing queued, nothing offered, no report outstanding
  task automatic wait_drained();
    do @(negedge clk); while (text_q.size() != 0 || s_tvalid || line_reports_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_pattern_word();
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    for (int k = 0; k < CFG_DATA_W / BYTE_W; k++)
      if (w[k*BYTE_W +: BYTE_W] == NEWLINE) w[k*BYTE_W +: BYTE_W] = 8'h41;
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] filler_byte(input int unsigned plen);
    if ($urandom_range(0, 1)) return pattern[$urandom_range(0, plen - 1)*BYTE_W +: BYTE_W];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_line(input bit end_stream);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] b;
    int unsigned       plen;
    int unsigned       n;
    plen = active_length();
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) body.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) body.push_back(filler_byte(plen));
      for (int k = 0; k < plen; k++) body.push_back(pattern[k*BYTE_W +: BYTE_W]);
      if ($urandom_range(0, 3) == 0) begin
        n = body.size() - 1 - $urandom_range(0, plen - 1);
        b = body[n];
        b[$urandom_range(0, BYTE_W - 1)] ^= 1'b1;
        body[n] = b;
      end else if ($urandom_range(0, 7) == 0) begin
        void'(body.pop_back());
      end
      n = $urandom_range(0, 4);
      repeat (n) body.push_back(filler_byte(plen));
    end
    if (end_stream && body.size() > 0 && $urandom_range(0, 1)) begin
      for (int k = 0; k < body.size(); k++) send(body[k], k == body.size() - 1);
    end else begin
      foreach (body[k]) send(body[k], 1'b0);
      send(NEWLINE, end_stream);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] lo, hi;
    logic [LEN_W-1:0]      len;
    int unsigned           directed_bytes;
    int unsigned           phase;
    int unsigned           lines;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pattern: one zero byte
    send(8'h00, 1'b0);
    send(NEWLINE, 1'b0);
    send(8'hFF, 1'b1);
    send(NEWLINE, 1'b1);
    wait_drained();

    // zero length behaves as one
    write_reg(REG_PATTERN_LOW, 64'h5A);
    write_reg(REG_PATTERN_LENGTH, '0);
    send(8'h5A, 1'b1);
    wait_drained();

    // length past the maximum behaves as the full sixteen bytes
    write_reg(REG_PATTERN_LOW, 64'hFF00_7E81_3C42_55AA);
    write_reg(REG_PATTERN_HIGH, 64'h8001_C3E7_18DB_F00F);
    write_reg(REG_PATTERN_LENGTH, 5'd31);
    for (int k = 0; k < PAT_BYTES; k++) send(pattern[k*BYTE_W +: BYTE_W], 1'b0);
    send(NEWLINE, 1'b1);
    directed_bytes = bytes_queued;

    phase = 0;
    while (bytes_queued - directed_bytes < RANDOM_BYTES) begin
      wait_drained();
      case (phase)
        0: begin
          lo  = '1;
          hi  = '1;
          len = 5'd16;
        end
        1: begin
          // newline inside the pattern: never matches
          lo  = random_pattern_word();
          lo[BYTE_W-1:0] = NEWLINE;
          hi  = random_pattern_word();
          len = LEN_W'($urandom_range(1, 3));
        end
        default: begin
          lo = random_pattern_word();
          hi = random_pattern_word();
          case ($urandom_range(0, 5))
            0:       len = '0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = LEN_W'($urandom_range(17, 31));
            default: len = LEN_W'($urandom_range(2, 15));
          endcase
        end
      endcase
      if (bytes_queued - directed_bytes > RANDOM_BYTES - 80) idle_on = 1'b0;
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LENGTH, len);
      if (phase == 1) hold_req = 1'b1;
      lines = $urandom_range(3, 8);
      for (int l = 0; l < lines; l++)
        queue_line(l == lines - 1 && $urandom_range(0, 4) != 0);
      phase++;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_line_substring_matcher_unit: done, clean");
    end else begin
      $display("tb_line_substring_matcher_unit: done, errors");
    end
    $finish;
  end

endmodule
